### hdl/isotropic_point_normalizer_assert.svh
// assertion macros shared by the point normalizer rtl
// no dependencies; included by files that check their own sequencing
`ifndef ISOTROPIC_POINT_NORMALIZER_ASSERT_SVH
`define ISOTROPIC_POINT_NORMALIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IPN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IPN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ipn_pkg.sv
// types, codes and helpers for the isotropic point normalizer
// no dependencies; used by every module of the block
`default_nettype none

package ipn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned DIV_W          = 64;
  localparam int unsigned SUM_W          = 40;
  localparam int unsigned TOT_W          = 40;
  localparam int unsigned RAD_W          = 66;
  localparam int unsigned ROOT_W         = 33;
  localparam int unsigned PROD_W         = 66;
  localparam logic [DIV_W-1:0] SQRT2_Q32 = 64'd6074001000;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FLAT     = 2'd1;
  localparam logic [1:0] ST_ZERO_W   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic KIND_XFORM = 1'b0;
  localparam logic KIND_PAIR  = 1'b1;

  typedef struct packed {
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_w;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_w;
    logic               final_pair;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic        [30:0] scale_one;
    logic        [30:0] scale_two;
    logic        [1:0]  status;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic signed [31:0] one_x;
    logic signed [31:0] one_y;
    logic signed [31:0] two_x;
    logic signed [31:0] two_y;
  } pair_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DH_GO, S_DH_WAIT, S_STORE,
    S_CEN_GO, S_CEN_WAIT, S_RD, S_SQA, S_SQB, S_SQ_GO, S_SQ_WAIT,
    S_MEAN_GO, S_MEAN_WAIT, S_SC_GO, S_SC_WAIT, S_TMUL, S_TFIN,
    S_EMIT_XF, S_PRD, S_PMUL, S_PACC, S_EMIT_PT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > PROD_W'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -PROD_W'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/ipn_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on ipn_pkg for the default width
`default_nettype none

module ipn_div #(
  parameter int unsigned W = ipn_pkg::DIV_W
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     num_q, den_q;
  logic [W:0]       rem_q;
  logic [W:0]       rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[W-1:0], num_q[W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], ge};
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

`default_nettype wire

### hdl/ipn_sqrt.sv
// digit-by-digit integer square root, floor of the root, two radicand bits a cycle
// depends on ipn_pkg for widths
`default_nettype none

module ipn_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ipn_pkg::RAD_W-1:0]   rad_i,
  output logic                             done_o,
  output logic [ipn_pkg::ROOT_W-1:0]       root_o
);

  localparam int unsigned RW = ipn_pkg::RAD_W;
  localparam int unsigned QW = ipn_pkg::ROOT_W;
  localparam int unsigned MW = QW + 3;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  logic [RW-1:0] rad_q;
  logic [QW-1:0] root_q;
  logic [MW-1:0] rem_q, rem_sh, trial;
  logic          ge;

  assign rem_sh = {rem_q[MW-3:0], rad_q[RW-1:RW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### hdl/isotropic_point_normalizer.sv
// Isotropic 2D point normalizer. Each accepted correspondence is dehomogenized
// with four passes of a shared 64-bit restoring divider (one quotient bit per
// cycle), then written to the pair store. A pair with a zero weight skips the
// divider and is stored as zeros, and a pair that arrives at a full store is
// dropped. The final pair then starts the fit. Per set this is two centroid
// divisions, then for every stored pair a memory read, two squares and a
// 33-step square root, then a mean division, a scale division unless the
// spread is zero, and two translation products. Results follow: one transform
// record, then the normalized pairs in order, their rate limited by the single
// 33x33 multiplier, which forms the products of each pair in turn, and held while
// the output is stalled. Input is taken only while the block is idle; the
// output register lets the last result wait while the next pair loads.
// Depends on ipn_pkg, ipn_div, ipn_sqrt and the assertion macro header.
`default_nettype none

`include "isotropic_point_normalizer_assert.svh"

module isotropic_point_normalizer #(
  parameter int unsigned MAX_POINTS = ipn_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = ipn_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ipn_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ipn_pkg::out_t      out_data_o
);

  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW  = ipn_pkg::DIV_W;
  localparam int unsigned PW  = ipn_pkg::PROD_W;
  localparam int          SH  = 2 * FRAC_BITS - 32;
  localparam int unsigned NSH = (SH > 0) ? SH : 0;
  localparam int unsigned DSH = (SH < 0) ? -SH : 0;

  ipn_pkg::state_e state_q, state_d;
  logic [1:0]       k_q, k_d;
  logic             set_q, set_d;
  logic [CW-1:0]    idx_q, idx_d, cnt_q, cnt_d;
  logic [1:0]       err_q, err_d;
  logic             flat_q, flat_d;
  ipn_pkg::in_t     in_q, in_d;
  logic signed [31:0] dh_q [4];
  logic signed [31:0] dh_d [4];
  logic signed [ipn_pkg::SUM_W-1:0] sum_q [4];
  logic signed [ipn_pkg::SUM_W-1:0] sum_d [4];
  logic signed [31:0] c_q [2];
  logic signed [31:0] c_d [2];
  logic [ipn_pkg::TOT_W-1:0] tot_q, tot_d;
  logic [32:0]      md_q, md_d;
  logic [64:0]      sa_q, sa_d;
  logic [30:0]      scale_q [2];
  logic [30:0]      scale_d [2];
  logic signed [31:0] t_q [4];
  logic signed [31:0] t_d [4];
  logic signed [31:0] res_q [4];
  logic signed [31:0] res_d [4];
  ipn_pkg::out_t    out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // pair store
  ipn_pkg::pair_t   mem [MAX_POINTS];
  ipn_pkg::pair_t   mem_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  ipn_pkg::pair_t   mem_wdata;

  // shared multiplier
  logic signed [32:0]   ma, mb;
  logic signed [PW-1:0] mul_q;

  // shared divider and root unit
  logic                 div_start, div_busy, div_done;
  logic [DW-1:0]        div_num, div_den, quo;
  logic                 sq_start, sq_done;
  logic [ipn_pkg::RAD_W-1:0]  sq_rad;
  logic [ipn_pkg::ROOT_W-1:0] root;

  // operand preparation
  logic signed [31:0]   dh_x, dh_w;
  logic [31:0]          dh_xm, dh_wm;
  logic                 dh_neg;
  logic signed [31:0]   dh_res;
  logic [DW-1:0]        n64, half_n;
  logic signed [ipn_pkg::SUM_W-1:0] sum_sel;
  logic [ipn_pkg::SUM_W-1:0] sum_mag;
  logic signed [31:0]   cur_x, cur_y, pt_v;
  logic signed [32:0]   dx, dy;
  logic [31:0]          adx, ady;
  logic [1:0]           st;
  logic                 w_zero, is_last;

  function automatic logic signed [PW-1:0] shr_rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[PW-1] ? -$signed(m) : $signed(m);
  endfunction

  ipn_div #(.W(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  ipn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign n64      = DW'(cnt_q);
  assign half_n   = n64 >> 1;
  assign w_zero   = (in_q.p1_w == '0) || (in_q.p2_w == '0);
  assign is_last  = (idx_q == cnt_q - CW'(1));
  assign st       = (err_q != ipn_pkg::ST_OK) ? err_q :
                    (flat_q ? ipn_pkg::ST_FLAT : ipn_pkg::ST_OK);

  // weight division operands
  always_comb begin
    unique case (k_q)
      2'd0:    dh_x = in_q.p1_x;
      2'd1:    dh_x = in_q.p1_y;
      2'd2:    dh_x = in_q.p2_x;
      default: dh_x = in_q.p2_y;
    endcase
    dh_w   = k_q[1] ? in_q.p2_w : in_q.p1_w;
    dh_xm  = dh_x[31] ? 32'(-dh_x) : 32'(dh_x);
    dh_wm  = dh_w[31] ? 32'(-dh_w) : 32'(dh_w);
    dh_neg = dh_x[31] ^ dh_w[31];
    if (dh_neg) begin
      dh_res = (quo > DW'(64'd2147483648)) ? 32'sh80000000 : -$signed(quo[31:0]);
    end else begin
      dh_res = (quo > DW'(64'd2147483647)) ? 32'sh7fffffff : $signed(quo[31:0]);
    end
  end

  // centroid and distance operands
  always_comb begin
    sum_sel = sum_q[{set_q, k_q[0]}];
    sum_mag = sum_sel[ipn_pkg::SUM_W-1] ? ipn_pkg::SUM_W'(-sum_sel)
                                        : ipn_pkg::SUM_W'(sum_sel);
    cur_x   = set_q ? mem_q.two_x : mem_q.one_x;
    cur_y   = set_q ? mem_q.two_y : mem_q.one_y;
    dx      = {cur_x[31], cur_x} - {c_q[0][31], c_q[0]};
    dy      = {cur_y[31], cur_y} - {c_q[1][31], c_q[1]};
    adx     = dx[32] ? 32'(-dx) : 32'(dx);
    ady     = dy[32] ? 32'(-dy) : 32'(dy);
    unique case (k_q)
      2'd0:    pt_v = mem_q.one_x;
      2'd1:    pt_v = mem_q.one_y;
      2'd2:    pt_v = mem_q.two_x;
      default: pt_v = mem_q.two_y;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipn_pkg::S_IDLE;
      k_q         <= '0;
      set_q       <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      err_q       <= ipn_pkg::ST_OK;
      flat_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) sum_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      set_q       <= set_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      flat_q      <= flat_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 4; i++) sum_q[i] <= sum_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    tot_q <= tot_d;
    md_q  <= md_d;
    sa_q  <= sa_d;
    out_q <= out_d;
    mul_q <= PW'(ma) * PW'(mb);
    for (int i = 0; i < 4; i++) begin
      dh_q[i]  <= dh_d[i];
      t_q[i]   <= t_d[i];
      res_q[i] <= res_d[i];
    end
    for (int i = 0; i < 2; i++) begin
      c_q[i]     <= c_d[i];
      scale_q[i] <= scale_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    set_d       = set_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    flat_d      = flat_q;
    in_d        = in_q;
    tot_d       = tot_q;
    md_d        = md_q;
    sa_d        = sa_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dh_d        = dh_q;
    sum_d       = sum_q;
    c_d         = c_q;
    scale_d     = scale_q;
    t_d         = t_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = idx_q[AW-1:0];
    mem_wdata   = '{one_x: dh_q[0], one_y: dh_q[1], two_x: dh_q[2], two_y: dh_q[3]};
    ma          = '0;
    mb          = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    sq_start    = 1'b0;
    sq_rad      = '0;

    unique case (state_q)
      ipn_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_d = in_data_i;
          k_d  = '0;
          if (cnt_q >= CW'(MAX_POINTS)) begin
            // store full: pair dropped, a final flag still starts the fit
            err_d = ipn_pkg::ST_OVERFLOW;
            if (in_data_i.final_pair) begin
              set_d   = 1'b0;
              state_d = ipn_pkg::S_CEN_GO;
            end
          end else if ((in_data_i.p1_w == '0) || (in_data_i.p2_w == '0)) begin
            for (int i = 0; i < 4; i++) dh_d[i] = '0;
            if (err_q < ipn_pkg::ST_ZERO_W) err_d = ipn_pkg::ST_ZERO_W;
            state_d = ipn_pkg::S_STORE;
          end else begin
            state_d = ipn_pkg::S_DH_GO;
          end
        end
      end
      ipn_pkg::S_DH_GO: begin
        div_start = 1'b1;
        div_num   = (DW'(dh_xm) << FRAC_BITS) + DW'(dh_wm[31:1]);
        div_den   = DW'(dh_wm);
        state_d   = ipn_pkg::S_DH_WAIT;
      end
      ipn_pkg::S_DH_WAIT: begin
        if (div_done) begin
          dh_d[k_q] = dh_res;
          if (k_q == 2'd3) state_d = ipn_pkg::S_STORE;
          else begin
            k_d     = k_q + 2'd1;
            state_d = ipn_pkg::S_DH_GO;
          end
        end
      end
      ipn_pkg::S_STORE: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q[AW-1:0];
        for (int i = 0; i < 4; i++) begin
          sum_d[i] = sum_q[i] + ipn_pkg::SUM_W'(dh_q[i]);
        end
        cnt_d = cnt_q + CW'(1);
        k_d   = '0;
        set_d = 1'b0;
        state_d = (in_q.final_pair && !w_zero) || in_q.final_pair ? ipn_pkg::S_CEN_GO
                                                                : ipn_pkg::S_IDLE;
      end
      ipn_pkg::S_CEN_GO: begin
        div_start = 1'b1;
        div_num   = DW'(sum_mag) + half_n;
        div_den   = n64;
        state_d   = ipn_pkg::S_CEN_WAIT;
      end
      ipn_pkg::S_CEN_WAIT: begin
        if (div_done) begin
          c_d[k_q[0]] = sum_sel[ipn_pkg::SUM_W-1] ? -$signed(quo[31:0])
                                                  : $signed(quo[31:0]);
          if (k_q[0]) begin
            idx_d   = '0;
            tot_d   = '0;
            state_d = ipn_pkg::S_RD;
          end else begin
            k_d     = 2'd1;
            state_d = ipn_pkg::S_CEN_GO;
          end
        end
      end
      ipn_pkg::S_RD: begin
        mem_re  = 1'b1;
        state_d = ipn_pkg::S_SQA;
      end
      ipn_pkg::S_SQA: begin
        ma      = {1'b0, adx};
        mb      = {1'b0, adx};
        state_d = ipn_pkg::S_SQB;
      end
      ipn_pkg::S_SQB: begin
        sa_d    = mul_q[64:0];
        ma      = {1'b0, ady};
        mb      = {1'b0, ady};
        state_d = ipn_pkg::S_SQ_GO;
      end
      ipn_pkg::S_SQ_GO: begin
        sq_start = 1'b1;
        sq_rad   = ipn_pkg::RAD_W'(sa_q) + ipn_pkg::RAD_W'(mul_q[64:0]);
        state_d  = ipn_pkg::S_SQ_WAIT;
      end
      ipn_pkg::S_SQ_WAIT: begin
        if (sq_done) begin
          tot_d = tot_q + ipn_pkg::TOT_W'(root);
          if (is_last) state_d = ipn_pkg::S_MEAN_GO;
          else begin
            idx_d   = idx_q + CW'(1);
            state_d = ipn_pkg::S_RD;
          end
        end
      end
      ipn_pkg::S_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = DW'(tot_q) + half_n;
        div_den   = n64;
        state_d   = ipn_pkg::S_MEAN_WAIT;
      end
      ipn_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          md_d = quo[32:0];
          k_d  = '0;
          if (quo == '0) begin
            // zero spread: scale zero, translation and points follow as zero
            flat_d         = 1'b1;
            scale_d[set_q] = '0;
            state_d        = ipn_pkg::S_TMUL;
          end else begin
            state_d = ipn_pkg::S_SC_GO;
          end
        end
      end
      ipn_pkg::S_SC_GO: begin
        div_start = 1'b1;
        div_den   = DW'(md_q) << DSH;
        div_num   = (ipn_pkg::SQRT2_Q32 << NSH) + (div_den >> 1);
        state_d   = ipn_pkg::S_SC_WAIT;
      end
      ipn_pkg::S_SC_WAIT: begin
        if (div_done) begin
          scale_d[set_q] = (quo > DW'(64'h7fffffff)) ? '1 : quo[30:0];
          state_d        = ipn_pkg::S_TMUL;
        end
      end
      ipn_pkg::S_TMUL: begin
        ma      = {2'b00, scale_q[set_q]};
        mb      = {c_q[k_q[0]][31], c_q[k_q[0]]};
        state_d = ipn_pkg::S_TFIN;
      end
      ipn_pkg::S_TFIN: begin
        t_d[{set_q, k_q[0]}] = ipn_pkg::sat32(-shr_rnd(mul_q));
        if (!k_q[0]) begin
          k_d     = 2'd1;
          state_d = ipn_pkg::S_TMUL;
        end else if (set_q) begin
          state_d = ipn_pkg::S_EMIT_XF;
        end else begin
          set_d   = 1'b1;
          k_d     = '0;
          state_d = ipn_pkg::S_CEN_GO;
        end
      end
      ipn_pkg::S_EMIT_XF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: ipn_pkg::KIND_XFORM, a_x: t_q[0], a_y: t_q[1],
                    b_x: t_q[2], b_y: t_q[3], scale_one: scale_q[0],
                    scale_two: scale_q[1], status: st, last_result: 1'b0};
          idx_d   = '0;
          state_d = ipn_pkg::S_PRD;
        end
      end
      ipn_pkg::S_PRD: begin
        mem_re  = 1'b1;
        k_d     = '0;
        state_d = ipn_pkg::S_PMUL;
      end
      ipn_pkg::S_PMUL: begin
        ma      = {2'b00, scale_q[k_q[1]]};
        mb      = {pt_v[31], pt_v};
        state_d = ipn_pkg::S_PACC;
      end
      ipn_pkg::S_PACC: begin
        res_d[k_q] = ipn_pkg::sat32(shr_rnd(mul_q) + PW'(t_q[k_q]));
        if (k_q == 2'd3) state_d = ipn_pkg::S_EMIT_PT;
        else begin
          k_d     = k_q + 2'd1;
          state_d = ipn_pkg::S_PMUL;
        end
      end
      ipn_pkg::S_EMIT_PT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: ipn_pkg::KIND_PAIR, a_x: res_q[0], a_y: res_q[1],
                    b_x: res_q[2], b_y: res_q[3], scale_one: '0, scale_two: '0,
                    status: st, last_result: is_last};
          if (is_last) begin
            cnt_d  = '0;
            err_d  = ipn_pkg::ST_OK;
            flat_d = 1'b0;
            for (int i = 0; i < 4; i++) sum_d[i] = '0;
            state_d = ipn_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ipn_pkg::S_PRD;
          end
        end
      end
      default: state_d = ipn_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IPN_ASSERT_NOW(a_div_free, clk_i, rst_ni, div_start, !div_busy, "divider started while busy")
  `IPN_ASSERT_NOW(a_rd_range, clk_i, rst_ni, mem_re, idx_q < cnt_q, "read past stored pairs")
  `IPN_ASSERT_NEXT(a_run_clear, clk_i, rst_ni,
    (state_q == ipn_pkg::S_EMIT_PT) && out_free && is_last,
    (cnt_q == '0) && (state_q == ipn_pkg::S_IDLE) && out_valid_q, "run state not cleared")

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the isotropic point normalizer
// depends on ipn_pkg and isotropic_point_normalizer; a scoreboard class holds
// a bit-true fit of each run and checks results in order
`default_nettype none

module tb_top;

  localparam int unsigned NPTS  = 32;
  localparam int unsigned FB    = 16;
  localparam int          WDOG  = 40000;

  class norm_scoreboard;
    int      one_x[NPTS], one_y[NPTS], two_x[NPTS], two_y[NPTS];
    int      pairs;
    longint  sums[4];
    logic [1:0] flags;
    ipn_pkg::out_t awaited[$];
    int      errors;

    function new();
      pairs = 0;
      flags = ipn_pkg::ST_OK;
      errors = 0;
      foreach (sums[i]) sums[i] = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint div_near(longint num, longint den);
      longint unsigned n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n + d / 2) / d;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function longint shift_near(longint v);
      longint unsigned m;
      m = ((v < 0 ? -v : v) + (64'd1 << (FB - 1))) >> FB;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function int dehom(int c, int w, ref bit zero_w);
      if (w == 0) begin
        zero_w = 1;
        return 0;
      end
      return int'(sat(div_near(longint'(c) * 65536, longint'(w))));
    endfunction

    // floor square root of dx^2 + dy^2 over the full 66-bit sum
    function longint unsigned radius(longint dx, longint dy);
      logic [67:0] a, b, v, root, t;
      a = dx < 0 ? -dx : dx;
      b = dy < 0 ? -dy : dy;
      v = a * a + b * b;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
        t = root | (68'd1 << i);
        if (t * t <= v) root = t;
      end
      return root[63:0];
    endfunction

    function void fit_set(const ref int xs[NPTS], const ref int ys[NPTS], longint sx,
                          longint sy, output longint s, output longint tx,
                          output longint ty, ref bit flat);
      longint cx, cy;
      longint unsigned total, q;
      cx = div_near(sx, pairs);
      cy = div_near(sy, pairs);
      total = 0;
      for (int i = 0; i < pairs; i++) total += radius(xs[i] - cx, ys[i] - cy);
      total = (total + pairs / 2) / pairs;
      if (total == 0) begin
        flat = 1;
        s = 0;
      end else begin
        q = (ipn_pkg::SQRT2_Q32 + total / 2) / total;
        s = q > 64'h7fffffff ? 64'h7fffffff : longint'(q);
      end
      tx = sat(-shift_near(s * cx));
      ty = sat(-shift_near(s * cy));
    endfunction

    function void note_input(ipn_pkg::in_t it);
      bit zero_w;
      int ax, ay, bx, by;
      longint s1, s2, t1x, t1y, t2x, t2y;
      bit flat;
      ipn_pkg::out_t r;
      if (pairs >= NPTS) begin
        flags = ipn_pkg::ST_OVERFLOW;
      end else begin
        zero_w = 0;
        ax = dehom(it.p1_x, it.p1_w, zero_w);
        ay = dehom(it.p1_y, it.p1_w, zero_w);
        bx = dehom(it.p2_x, it.p2_w, zero_w);
        by = dehom(it.p2_y, it.p2_w, zero_w);
        if (zero_w) begin
          ax = 0; ay = 0; bx = 0; by = 0;
          if (flags < ipn_pkg::ST_ZERO_W) flags = ipn_pkg::ST_ZERO_W;
        end
        one_x[pairs] = ax; one_y[pairs] = ay;
        two_x[pairs] = bx; two_y[pairs] = by;
        sums[0] += ax; sums[1] += ay; sums[2] += bx; sums[3] += by;
        pairs++;
      end
      if (!it.final_pair) return;
      flat = 0;
      fit_set(one_x, one_y, sums[0], sums[1], s1, t1x, t1y, flat);
      fit_set(two_x, two_y, sums[2], sums[3], s2, t2x, t2y, flat);
      if (flags == ipn_pkg::ST_OK && flat) flags = ipn_pkg::ST_FLAT;
      r.kind = ipn_pkg::KIND_XFORM;
      r.a_x = 32'(t1x); r.a_y = 32'(t1y); r.b_x = 32'(t2x); r.b_y = 32'(t2y);
      r.scale_one = s1[30:0]; r.scale_two = s2[30:0];
      r.status = flags;
      r.last_result = 1'b0;
      awaited.push_back(r);
      for (int i = 0; i < pairs; i++) begin
        r.kind = ipn_pkg::KIND_PAIR;
        r.a_x = 32'(sat(shift_near(s1 * one_x[i]) + t1x));
        r.a_y = 32'(sat(shift_near(s1 * one_y[i]) + t1y));
        r.b_x = 32'(sat(shift_near(s2 * two_x[i]) + t2x));
        r.b_y = 32'(sat(shift_near(s2 * two_y[i]) + t2y));
        r.scale_one = '0; r.scale_two = '0;
        awaited.push_back(r);
      end
      awaited[awaited.size() - 1].last_result = 1'b1;
      pairs = 0;
      foreach (sums[i]) sums[i] = 0;
      flags = ipn_pkg::ST_OK;
    endfunction

    function void check(ipn_pkg::out_t got);
      ipn_pkg::out_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
      end
      if (got.a_x !== e.a_x) begin
        $error("a_x: expected %0d, got %0d", e.a_x, got.a_x); errors++;
      end
      if (got.a_y !== e.a_y) begin
        $error("a_y: expected %0d, got %0d", e.a_y, got.a_y); errors++;
      end
      if (got.b_x !== e.b_x) begin
        $error("b_x: expected %0d, got %0d", e.b_x, got.b_x); errors++;
      end
      if (got.b_y !== e.b_y) begin
        $error("b_y: expected %0d, got %0d", e.b_y, got.b_y); errors++;
      end
      if (got.scale_one !== e.scale_one) begin
        $error("scale_one: expected %0d, got %0d", e.scale_one, got.scale_one); errors++;
      end
      if (got.scale_two !== e.scale_two) begin
        $error("scale_two: expected %0d, got %0d", e.scale_two, got.scale_two); errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.last_result !== e.last_result) begin
        $error("last_result: expected %0d, got %0d", e.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ipn_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ipn_pkg::out_t out_data;

  norm_scoreboard sb = new();
  bit   burst = 1'b0;
  int   sent = 0;
  int   idle_cycles = 0;

  isotropic_point_normalizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // valid is lowered only when a gap follows, so it never toggles within a step
  task automatic send(input ipn_pkg::in_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic ipn_pkg::in_t rand_pair(bit last);
    ipn_pkg::in_t it;
    int  mode;
    mode = $urandom_range(0, 19);
    it.p1_x = $signed($urandom_range(0, 2000)) - 1000;
    it.p1_y = $signed($urandom_range(0, 2000)) - 1000;
    it.p2_x = $signed($urandom_range(0, 2000)) - 1000;
    it.p2_y = $signed($urandom_range(0, 2000)) - 1000;
    it.p1_x = it.p1_x <<< FB; it.p1_y = it.p1_y <<< FB;
    it.p2_x = it.p2_x <<< FB; it.p2_y = it.p2_y <<< FB;
    it.p1_w = 32'sh10000;
    it.p2_w = 32'sh10000;
    if (mode < 4) begin
      it.p1_w = $urandom_range(32'h8000, 32'h40000);
      it.p2_w = -$signed($urandom_range(32'h8000, 32'h40000));
    end else if (mode < 6) begin
      it.p1_x = $urandom; it.p1_y = $urandom; it.p1_w = $urandom;
      it.p2_x = $urandom; it.p2_y = $urandom; it.p2_w = $urandom;
    end else if (mode == 6) begin
      if ($urandom_range(0, 1)) it.p1_w = 0;
      else it.p2_w = 0;
    end
    it.final_pair = last;
    return it;
  endfunction

  function automatic ipn_pkg::in_t mk(int x1, int y1, int w1, int x2, int y2, int w2,
                                      bit last);
    ipn_pkg::in_t it;
    it.p1_x = x1; it.p1_y = y1; it.p1_w = w1;
    it.p2_x = x2; it.p2_y = y2; it.p2_w = w2;
    it.final_pair = last;
    return it;
  endfunction

  // ready side: random stalls, with bursts of none
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check(out_data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pair: zero spread
    send(mk(32'sh10000, 32'sh20000, 32'sh10000, 32'sh30000, -32'sh10000, 32'sh10000, 1));
    // field extremes, saturating division and negative weights
    send(mk(32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh80000000, 32'sh7fffffff,
            32'shffffffff, 0));
    send(mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 0));
    send(mk(0, 32'sh12345, 32'sh10000, 32'sh7fffffff, 0, 32'sh10000, 1));
    // zero weight in both pairs, first on one side and then on the other
    send(mk(32'sh50000, 32'sh60000, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0));
    send(mk(32'sh10000, 32'sh20000, 32'sh10000, 32'sh10000, 32'sh10000, 0, 1));
    // identical points give a flat set
    send(mk(32'sh40000, 32'sh40000, 32'sh20000, -32'sh1000, 32'sh5000, 32'sh10000, 0));
    send(mk(32'sh20000, 32'sh20000, 32'sh10000, 32'sh3000, -32'sh7000, 32'sh10000, 0));
    send(mk(32'sh80000, 32'sh80000, 32'sh40000, 32'sh9000, 32'sh2000, 32'sh10000, 1));
    // hold off until every result of the directed part is in
    in_valid <= 1'b0;
    drain();

    while (sent < 310) begin
      if ($urandom_range(0, 7) == 0) burst = ~burst;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 6);
      for (int i = 1; i <= len; i++) send(rand_pair(i == len));
    end
    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/ipn_pkg.sv
hdl/ipn_div.sv
hdl/ipn_sqrt.sv
hdl/isotropic_point_normalizer.sv
tb/tb_top.sv
